/* src/charge_hysteresis_controller_unit_defines.svh */
// Assertion macros used by the charge hysteresis controller top level.
`ifndef CHARGE_HYSTERESIS_CONTROLLER_UNIT_DEFINES_SVH
`define CHARGE_HYSTERESIS_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/chc_pkg.sv */
// Types, codes and constants shared by the charge hysteresis controller.
package chc_pkg;

  localparam int TICK_WIDTH_DEF = 16;

  localparam logic [3:0]  STREAK_MAX           = 4'd15;
  localparam logic [15:0] FULL_IMPLAUSIBLE_MV  = 16'd3900;
  localparam logic [15:0] EMPTY_IMPLAUSIBLE_MV = 16'd3500;
  localparam logic [7:0]  LEVEL_FULL_CONST     = 8'd100;
  localparam logic [1:0]  CHG_DONE             = 2'd3;

  localparam logic [6:0]  RST_FULL_LEVEL  = 7'd100;
  localparam logic [15:0] RST_MIN_STOP    = 16'd4100;
  localparam logic [15:0] RST_RESUME      = 16'd4000;
  localparam logic [15:0] RST_CRITICAL    = 16'd3300;
  localparam logic [3:0]  RST_DEBOUNCE    = 4'd3;
  localparam logic [15:0] RST_COOLDOWN    = 16'd15000;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    KIND_TICK   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CHANGE_NONE   = 2'd0,
    CHANGE_STOP   = 2'd1,
    CHANGE_RESUME = 2'd2
  } change_t;

  typedef enum logic [2:0] {
    REG_FULL_LEVEL = 3'd0,
    REG_MIN_STOP   = 3'd1,
    REG_RESUME     = 3'd2,
    REG_CRITICAL   = 3'd3,
    REG_DEBOUNCE   = 3'd4,
    REG_COOLDOWN   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]  full_level_pct;
    logic [15:0] min_stop_mv;
    logic [15:0] resume_mv;
    logic [15:0] critical_mv;
    logic [3:0]  debounce_needed;
    logic [15:0] cooldown_ticks;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  level_pct;
    logic [15:0] battery_mv;
    logic [1:0]  charger_status;
    logic [6:0]  estimated_pct;
  } item_t;

  typedef struct packed {
    logic        charging_on;
    change_t     change;
    logic        crit_low;
    logic [3:0]  streak;
    logic [7:0]  used_level_pct;
  } res_t;

endpackage

/* src/chc_regs.sv */
// Configuration register file behind the APB-style port.
module chc_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [chc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [chc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output chc_pkg::cfg_t                     cfg
);
  import chc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_level_pct  <= RST_FULL_LEVEL;
      cfg_r.min_stop_mv     <= RST_MIN_STOP;
      cfg_r.resume_mv       <= RST_RESUME;
      cfg_r.critical_mv     <= RST_CRITICAL;
      cfg_r.debounce_needed <= RST_DEBOUNCE;
      cfg_r.cooldown_ticks  <= RST_COOLDOWN;
    end else if (wr_en) begin
      unique case (idx)
        REG_FULL_LEVEL: cfg_r.full_level_pct  <= pwdata[6:0];
        REG_MIN_STOP:   cfg_r.min_stop_mv     <= pwdata[15:0];
        REG_RESUME:     cfg_r.resume_mv       <= pwdata[15:0];
        REG_CRITICAL:   cfg_r.critical_mv     <= pwdata[15:0];
        REG_DEBOUNCE:   cfg_r.debounce_needed <= pwdata[3:0];
        REG_COOLDOWN:   cfg_r.cooldown_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FULL_LEVEL: prdata = {25'd0, cfg_r.full_level_pct};
      REG_MIN_STOP:   prdata = {16'd0, cfg_r.min_stop_mv};
      REG_RESUME:     prdata = {16'd0, cfg_r.resume_mv};
      REG_CRITICAL:   prdata = {16'd0, cfg_r.critical_mv};
      REG_DEBOUNCE:   prdata = {28'd0, cfg_r.debounce_needed};
      REG_COOLDOWN:   prdata = {16'd0, cfg_r.cooldown_ticks};
      default:        prdata = '0;
    endcase
  end

endmodule

/* src/chc_core.sv */
// Charge state, debounce streaks and tick counter with their update logic.
module chc_core #(
  parameter int TICK_WIDTH = chc_pkg::TICK_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  chc_pkg::item_t item,
  input  chc_pkg::cfg_t  cfg,
  output chc_pkg::res_t  res
);
  import chc_pkg::*;

  localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

  logic                  charging_r, charging_nxt;
  logic [3:0]            stop_streak_r, stop_streak_nxt;
  logic [3:0]            resume_streak_r, resume_streak_nxt;
  logic [TICK_WIDTH-1:0] ticks_r, ticks_nxt;
  logic                  toggled_r, toggled_nxt;

  logic [7:0] used_level;
  logic       allowed;
  logic       stop_rd;
  logic       resume_rd;
  logic [3:0] stop_inc;
  logic [3:0] resume_inc;

  always_comb begin
    if ((item.level_pct >= LEVEL_FULL_CONST) && (item.battery_mv < FULL_IMPLAUSIBLE_MV)) begin
      used_level = {1'b0, item.estimated_pct};
    end else if ((item.level_pct == 8'd0) && (item.battery_mv > EMPTY_IMPLAUSIBLE_MV)) begin
      used_level = {1'b0, item.estimated_pct};
    end else begin
      used_level = item.level_pct;
    end
  end

  assign allowed = !toggled_r ||
                   (CMP_W'(ticks_r) >= CMP_W'(cfg.cooldown_ticks));
  // A full or done reading is vetoed while the voltage is below the stop floor.
  assign stop_rd = ((item.charger_status == CHG_DONE) ||
                    (used_level >= {1'b0, cfg.full_level_pct})) &&
                   (item.battery_mv >= cfg.min_stop_mv);
  assign resume_rd = (item.battery_mv != 16'd0) && (item.battery_mv < cfg.resume_mv);
  assign stop_inc   = (stop_streak_r   < STREAK_MAX) ? stop_streak_r + 4'd1   : STREAK_MAX;
  assign resume_inc = (resume_streak_r < STREAK_MAX) ? resume_streak_r + 4'd1 : STREAK_MAX;

  always_comb begin
    charging_nxt      = charging_r;
    stop_streak_nxt   = stop_streak_r;
    resume_streak_nxt = resume_streak_r;
    ticks_nxt         = ticks_r;
    toggled_nxt       = toggled_r;
    res.change        = CHANGE_NONE;
    if (item.kind == KIND_TICK) begin
      if (ticks_r != {TICK_WIDTH{1'b1}}) begin
        ticks_nxt = ticks_r + TICK_WIDTH'(1);
      end
    end else if (charging_r) begin
      if (stop_rd) begin
        stop_streak_nxt   = stop_inc;
        resume_streak_nxt = 4'd0;
        if ((stop_inc >= cfg.debounce_needed) && allowed) begin
          charging_nxt    = 1'b0;
          stop_streak_nxt = 4'd0;
          ticks_nxt       = '0;
          toggled_nxt     = 1'b1;
          res.change      = CHANGE_STOP;
        end
      end else begin
        stop_streak_nxt = 4'd0;
      end
    end else begin
      if (resume_rd) begin
        resume_streak_nxt = resume_inc;
        stop_streak_nxt   = 4'd0;
        if ((resume_inc >= cfg.debounce_needed) && allowed) begin
          charging_nxt      = 1'b1;
          resume_streak_nxt = 4'd0;
          ticks_nxt         = '0;
          toggled_nxt       = 1'b1;
          res.change        = CHANGE_RESUME;
        end
      end else begin
        resume_streak_nxt = 4'd0;
      end
    end
    res.charging_on    = charging_nxt;
    res.crit_low       = (item.battery_mv != 16'd0) && (item.battery_mv <= cfg.critical_mv);
    res.streak         = charging_r ? stop_streak_nxt : resume_streak_nxt;
    res.used_level_pct = used_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charging_r      <= 1'b1;
      stop_streak_r   <= 4'd0;
      resume_streak_r <= 4'd0;
      ticks_r         <= '0;
      toggled_r       <= 1'b0;
    end else if (step_en) begin
      charging_r      <= charging_nxt;
      stop_streak_r   <= stop_streak_nxt;
      resume_streak_r <= resume_streak_nxt;
      ticks_r         <= ticks_nxt;
      toggled_r       <= toggled_nxt;
    end
  end

endmodule

/* src/charge_hysteresis_controller_unit.sv */
// Top level of the battery charge hysteresis controller with debounce.
`include "charge_hysteresis_controller_unit_defines.svh"

// The block takes one word a cycle on the input channel, either a time tick or
// a battery sample. Each word sits in an input register while the decision
// logic reads it together with the charge state, and a sample then writes its
// result word into the output register, from which it is taken; one word is
// taken every cycle when the result side does not stall. A tick updates the
// tick counter and yields no result; it moves on even while a result waits to
// be taken. A sample waits in the input register only while the output
// register is full and stalled, which is the one thing that sets the rate.
// Charging starts enabled after reset. The user must write the debounce,
// cooldown and voltage thresholds through the register port only while no
// word is in flight; the block does not enforce this. The counter of ticks
// since the last toggle is TICK_WIDTH bits wide and saturates.
module charge_hysteresis_controller_unit #(
  parameter int TICK_WIDTH = chc_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [7:0]                     in_level_pct,
  input  logic [15:0]                    in_battery_mv,
  input  logic [1:0]                     in_charger_status,
  input  logic [6:0]                     in_estimated_pct,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_charging_on,
  output logic [1:0]                     out_change,
  output logic                           out_crit_low,
  output logic [3:0]                     out_streak,
  output logic [7:0]                     out_used_level_pct,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [chc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [chc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [chc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import chc_pkg::*;

  cfg_t  cfg;
  item_t s1_r;
  logic  s1_valid_r, s1_valid_nxt;
  res_t  res;
  res_t  out_r;
  logic  out_valid_r, out_valid_nxt;
  logic  in_take;
  logic  advance;
  logic  adv_sample;

  chc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A tick never needs the output register; a sample needs it empty or
  // being emptied in this same cycle.
  assign advance    = s1_valid_r &&
                      ((s1_r.kind == KIND_TICK) || !out_valid_r || !out_stall);
  assign adv_sample = advance && (s1_r.kind == KIND_SAMPLE);
  assign in_stall   = s1_valid_r && !advance;
  assign in_take    = in_valid && !in_stall;

  chc_core #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv_sample) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.kind           <= kind_t'(in_kind);
      s1_r.level_pct      <= in_level_pct;
      s1_r.battery_mv     <= in_battery_mv;
      s1_r.charger_status <= in_charger_status;
      s1_r.estimated_pct  <= in_estimated_pct;
    end
    if (adv_sample) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_charging_on    = out_r.charging_on;
  assign out_change         = out_r.change;
  assign out_crit_low       = out_r.crit_low;
  assign out_streak         = out_r.streak;
  assign out_used_level_pct = out_r.used_level_pct;

  // A sample must never overwrite a result word that is still held back.
  `CHC_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !adv_sample, "result word overwritten while stalled")
  // A stop leaves charging off and a resume leaves it on.
  `CHC_ASSERT_NOW(a_change_dir, clk, rst_n, out_valid_r && (out_r.change != CHANGE_NONE), out_r.charging_on == (out_r.change == CHANGE_RESUME), "change code disagrees with charging state")
  // A toggle always clears the streak it reports.
  `CHC_ASSERT_NOW(a_toggle_streak, clk, rst_n, out_valid_r && (out_r.change != CHANGE_NONE), out_r.streak == 4'd0, "streak not cleared on toggle")
  // A word held in the input register with a free result side moves on.
  `CHC_ASSERT_NEXT(a_drain, clk, rst_n, s1_valid_r && !out_valid_r && !in_valid, !s1_valid_r, "input register failed to drain")

endmodule

/* verif/charge_decision_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts each result word of the charge controller and compares it.
module charge_decision_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_kind,
  input  logic [7:0]                     in_level_pct,
  input  logic [15:0]                    in_battery_mv,
  input  logic [1:0]                     in_charger_status,
  input  logic [6:0]                     in_estimated_pct,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_charging_on,
  input  logic [1:0]                     out_change,
  input  logic                           out_crit_low,
  input  logic [3:0]                     out_streak,
  input  logic [7:0]                     out_used_level_pct,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [chc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [chc_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             outstanding,
  output int                             fail_count
);
  import chc_pkg::*;

  cfg_t        regs;
  logic        charging;
  logic [3:0]  stop_run;
  logic [3:0]  resume_run;
  logic [15:0] ticks_since;
  logic        toggled;
  res_t        expected_q[$];
  int          failures;
  int          words_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    failures++;
    $display("%0t: result word %0d: %s is %0d, expected %0d", $realtime, words_seen, what,
             got, want);
  endtask

  // Advances the controller state by one sample and returns the word it yields.
  function automatic res_t decide(input item_t it);
    res_t       r;
    logic [7:0] level;
    logic       allowed;
    logic       reading;
    level = it.level_pct;
    if (level >= LEVEL_FULL_CONST && it.battery_mv < FULL_IMPLAUSIBLE_MV)
      level = {1'b0, it.estimated_pct};
    else if (level == 8'd0 && it.battery_mv > EMPTY_IMPLAUSIBLE_MV)
      level = {1'b0, it.estimated_pct};
    allowed = !toggled || ticks_since >= regs.cooldown_ticks;
    r.change = CHANGE_NONE;
    if (charging) begin
      reading = (it.charger_status == CHG_DONE || level >= {1'b0, regs.full_level_pct}) &&
                it.battery_mv >= regs.min_stop_mv;
      if (reading) begin
        if (stop_run != STREAK_MAX) stop_run++;
        resume_run = 4'd0;
        if (stop_run >= regs.debounce_needed && allowed) begin
          charging    = 1'b0;
          stop_run    = 4'd0;
          ticks_since = 16'd0;
          toggled     = 1'b1;
          r.change    = CHANGE_STOP;
        end
      end else begin
        stop_run = 4'd0;
      end
      r.streak = stop_run;
    end else begin
      reading = it.battery_mv != 16'd0 && it.battery_mv < regs.resume_mv;
      if (reading) begin
        if (resume_run != STREAK_MAX) resume_run++;
        stop_run = 4'd0;
        if (resume_run >= regs.debounce_needed && allowed) begin
          charging    = 1'b1;
          resume_run  = 4'd0;
          ticks_since = 16'd0;
          toggled     = 1'b1;
          r.change    = CHANGE_RESUME;
        end
      end else begin
        resume_run = 4'd0;
      end
      r.streak = resume_run;
    end
    r.charging_on    = charging;
    r.crit_low       = it.battery_mv != 16'd0 && it.battery_mv <= regs.critical_mv;
    r.used_level_pct = level;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    item_t it;
    res_t  got;
    res_t  want;
    if (!rst_n) begin
      regs        = '{RST_FULL_LEVEL, RST_MIN_STOP, RST_RESUME, RST_CRITICAL, RST_DEBOUNCE,
                      RST_COOLDOWN};
      charging    = 1'b1;
      stop_run    = 4'd0;
      resume_run  = 4'd0;
      ticks_since = 16'd0;
      toggled     = 1'b0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_FULL_LEVEL: regs.full_level_pct  = pwdata[6:0];
          REG_MIN_STOP:   regs.min_stop_mv     = pwdata[15:0];
          REG_RESUME:     regs.resume_mv       = pwdata[15:0];
          REG_CRITICAL:   regs.critical_mv     = pwdata[15:0];
          REG_DEBOUNCE:   regs.debounce_needed = pwdata[3:0];
          REG_COOLDOWN:   regs.cooldown_ticks  = pwdata[15:0];
          default: ;
        endcase
      end
      // Results leave before the word accepted on this edge can have produced one.
      if (out_valid && !out_stall) begin
        got.charging_on    = out_charging_on;
        got.change         = change_t'(out_change);
        got.crit_low       = out_crit_low;
        got.streak         = out_streak;
        got.used_level_pct = out_used_level_pct;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word, change", int'(got.change), 0);
        end else begin
          want = expected_q.pop_front();
          if (got.charging_on !== want.charging_on)
            report_mismatch("charging_on", int'(got.charging_on), int'(want.charging_on));
          if (got.change !== want.change)
            report_mismatch("change", int'(got.change), int'(want.change));
          if (got.crit_low !== want.crit_low)
            report_mismatch("crit_low", int'(got.crit_low), int'(want.crit_low));
          if (got.streak !== want.streak)
            report_mismatch("streak", int'(got.streak), int'(want.streak));
          if (got.used_level_pct !== want.used_level_pct)
            report_mismatch("used_level_pct", int'(got.used_level_pct),
                            int'(want.used_level_pct));
        end
        words_seen++;
      end
      if (in_valid && !in_stall) begin
        it.kind           = kind_t'(in_kind);
        it.level_pct      = in_level_pct;
        it.battery_mv     = in_battery_mv;
        it.charger_status = in_charger_status;
        it.estimated_pct  = in_estimated_pct;
        if (it.kind == KIND_TICK) begin
          if (ticks_since != 16'hFFFF) ticks_since++;
        end else begin
          expected_q.push_back(decide(it));
        end
      end
    end
    outstanding <= expected_q.size();
    fail_count  <= failures;
  end

endmodule

/* verif/tb_charge_hysteresis_controller_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the charge hysteresis controller: stimulus, flow control and verdict.
module tb_charge_hysteresis_controller_unit;
  import chc_pkg::*;

  // Generous ceiling on the run; the slowest legal run stays well below it.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles to let the pipeline settle once nothing is expected any more.
  localparam int SETTLE      = 6;
  // Length of the deliberate long stall on the result side.
  localparam int LONG_HOLD   = 60;

  // Kinds of run that the random sender strings together.
  typedef enum int {RUN_STOP, RUN_RESUME, RUN_NOISE, RUN_TICKS} run_t;
  // Stall patterns of the result side.
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [7:0]            in_level_pct;
  logic [15:0]           in_battery_mv;
  logic [1:0]            in_charger_status;
  logic [6:0]            in_estimated_pct;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_charging_on;
  logic [1:0]            out_change;
  logic                  out_crit_low;
  logic [3:0]            out_streak;
  logic [7:0]            out_used_level_pct;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int   outstanding;
  int   fail_count;
  int   cycle_count = 0;
  // The sender raises hold_reqs; the stall process serves each request in turn.
  int   hold_reqs = 0;
  int   holds_served = 0;
  // The sender's own copy of the register settings, used to aim its stimulus.
  cfg_t cur_cfg;

  charge_hysteresis_controller_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_level_pct       (in_level_pct),
    .in_battery_mv      (in_battery_mv),
    .in_charger_status  (in_charger_status),
    .in_estimated_pct   (in_estimated_pct),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charging_on    (out_charging_on),
    .out_change         (out_change),
    .out_crit_low       (out_crit_low),
    .out_streak         (out_streak),
    .out_used_level_pct (out_used_level_pct),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  charge_decision_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_level_pct       (in_level_pct),
    .in_battery_mv      (in_battery_mv),
    .in_charger_status  (in_charger_status),
    .in_estimated_pct   (in_estimated_pct),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charging_on    (out_charging_on),
    .out_change         (out_change),
    .out_crit_low       (out_crit_low),
    .out_streak         (out_streak),
    .out_used_level_pct (out_used_level_pct),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .outstanding        (outstanding),
    .fail_count         (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a run that has not finished by now is hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The result side stalls on a pattern of its own: segments of random length, each with
  // no stalls, light or heavy random stalls, or strict alternation. A pending hold request
  // overrides the pattern with a long unbroken stall so that the block fills up.
  initial begin : result_stall
    int     seg_left;
    int     held;
    stall_t seg_mode;
    seg_left  = 0;
    held      = 0;
    seg_mode  = STALL_NONE;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        out_stall <= 1'b1;
        held++;
        if (held == LONG_HOLD) begin
          held = 0;
          holds_served++;
        end
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 60);
          seg_mode = stall_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (seg_mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall <= ~out_stall;
          default:      out_stall <= 1'b0;
        endcase
      end
    end
  end

  function automatic item_t make_sample(input int level, input int mv, input int status,
                                        input int est);
    item_t it;
    it.kind           = KIND_SAMPLE;
    it.level_pct      = 8'(level);
    it.battery_mv     = 16'(mv);
    it.charger_status = 2'(status);
    it.estimated_pct  = 7'(est);
    return it;
  endfunction

  // Builds one random word aimed at the given kind of run. Stop and resume runs are the
  // well-formed sequences that drive the debounce towards a toggle; ticks are sprinkled
  // through them so that short cooldowns expire along the way.
  function automatic item_t rand_item(input run_t mode);
    item_t it;
    int    pick;
    it = make_sample($urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 3),
                     $urandom_range(0, 100));
    case (mode)
      RUN_TICKS: it.kind = KIND_TICK;
      RUN_STOP: begin
        if ($urandom_range(0, 4) == 0) it.kind = KIND_TICK;
        it.battery_mv = 16'($urandom_range(cur_cfg.min_stop_mv, 16'hFFFF));
        if ($urandom_range(0, 3) == 0) it.battery_mv = cur_cfg.min_stop_mv;
        if ($urandom_range(0, 1) == 0) it.charger_status = CHG_DONE;
        else it.level_pct = 8'($urandom_range(cur_cfg.full_level_pct, 255));
      end
      RUN_RESUME: begin
        if ($urandom_range(0, 4) == 0) it.kind = KIND_TICK;
        if (cur_cfg.resume_mv > 16'd1) begin
          it.battery_mv = 16'($urandom_range(1, cur_cfg.resume_mv - 16'd1));
          if ($urandom_range(0, 3) == 0) it.battery_mv = cur_cfg.resume_mv - 16'd1;
        end
      end
      default: begin
        // Noise: values sitting on the thresholds and the plausibility limits.
        pick = $urandom_range(0, 10);
        case (pick)
          0: it.battery_mv = 16'd0;
          1: it.battery_mv = cur_cfg.critical_mv;
          2: it.battery_mv = 16'(cur_cfg.critical_mv + 1);
          3: it.battery_mv = EMPTY_IMPLAUSIBLE_MV;
          4: it.battery_mv = EMPTY_IMPLAUSIBLE_MV + 16'd1;
          5: it.battery_mv = FULL_IMPLAUSIBLE_MV - 16'd1;
          6: it.battery_mv = FULL_IMPLAUSIBLE_MV;
          7: it.battery_mv = 16'(cur_cfg.min_stop_mv - 1);
          8: it.battery_mv = cur_cfg.resume_mv;
          9: it.battery_mv = 16'hFFFF;
          default: ;
        endcase
        pick = $urandom_range(0, 5);
        case (pick)
          0: it.level_pct = 8'd0;
          1: it.level_pct = LEVEL_FULL_CONST;
          2: it.level_pct = LEVEL_FULL_CONST - 8'd1;
          3: it.level_pct = {1'b0, cur_cfg.full_level_pct};
          default: ;
        endcase
      end
    endcase
    return it;
  endfunction

  // Offers one word and holds it steady until the block takes it. The caller either
  // offers the next word straight away or drops valid, so valid is never lowered and
  // raised again on the same edge.
  task automatic send(input item_t it);
    in_valid          <= 1'b1;
    in_kind           <= it.kind;
    in_level_pct      <= it.level_pct;
    in_battery_mv     <= it.battery_mv;
    in_charger_status <= it.charger_status;
    in_estimated_pct  <= it.estimated_pct;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering words and waits until every expected result word has come back, then
  // waits out the SETTLE period for any tick still travelling through the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all six registers back to back over the register port. Each write has a setup
  // phase and an access phase held until pready; the next setup follows the access directly.
  task automatic configure(input cfg_t c);
    logic [15:0] value;
    for (int i = 0; i < 6; i++) begin
      case (reg_idx_t'(i))
        REG_FULL_LEVEL: value = {9'd0, c.full_level_pct};
        REG_MIN_STOP:   value = c.min_stop_mv;
        REG_RESUME:     value = c.resume_mv;
        REG_CRITICAL:   value = c.critical_mv;
        REG_DEBOUNCE:   value = {12'd0, c.debounce_needed};
        default:        value = c.cooldown_ticks;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_t'(i), 2'b00};
      pwdata  <= {16'd0, value};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = c;
  endtask

  // Random traffic in bursts of random length with random gaps, some bursts long and
  // gap-free. Within the bursts the words come in runs of one kind, with the odd stray
  // word to break a run up.
  task automatic run_random(input int n_items);
    int    sent;
    int    burst;
    int    gap;
    int    run_left;
    int    pick;
    run_t  mode;
    item_t it;
    sent     = 0;
    run_left = 0;
    mode     = RUN_NOISE;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      repeat (burst) begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 19);
          if (pick < 8) begin
            mode     = RUN_STOP;
            run_left = $urandom_range(1, 20);
          end else if (pick < 15) begin
            mode     = RUN_RESUME;
            run_left = $urandom_range(1, 20);
          end else if (pick < 18) begin
            mode     = RUN_NOISE;
            run_left = $urandom_range(1, 6);
          end else begin
            mode     = RUN_TICKS;
            run_left = $urandom_range(1, 30);
          end
        end
        run_left--;
        it = ($urandom_range(0, 9) == 0) ? rand_item(RUN_NOISE) : rand_item(mode);
        send(it);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_kind           = 1'b0;
    in_level_pct      = 8'd0;
    in_battery_mv     = 16'd0;
    in_charger_status = 2'd0;
    in_estimated_pct  = 7'd0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cur_cfg = '{RST_FULL_LEVEL, RST_MIN_STOP, RST_RESUME, RST_CRITICAL, RST_DEBOUNCE,
                RST_COOLDOWN};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings: full 100 %, stop floor 4100 mV, resume
    // below 4000 mV, critical at 3300 mV, three readings to toggle, long cooldown.
    send(rand_item(RUN_TICKS));
    send(make_sample(255, 65535, 0, 100));     // largest level and voltage: a stop reading
    send(make_sample(100, 3899, 0, 55));       // full level at low voltage swaps to estimate
    send(make_sample(0, 3501, 1, 80));         // empty level at high voltage swaps too
    send(make_sample(0, 3500, 2, 80));         // exactly on the limit: level is kept
    send(make_sample(50, 0, 0, 0));            // unknown voltage is never critical
    send(make_sample(50, 3300, 0, 0));         // critical at the threshold itself
    send(make_sample(50, 3301, 0, 0));
    send(make_sample(50, 1, 0, 0));
    send(make_sample(50, 4099, CHG_DONE, 0));  // charger done, but vetoed by the floor
    send(make_sample(50, 4100, CHG_DONE, 0));  // charger done right on the floor
    send(make_sample(99, 4200, 0, 0));         // just short of full breaks the streak
    send(make_sample(100, 4200, 0, 0));
    send(make_sample(101, 4200, 1, 0));
    send(make_sample(0, 4100, CHG_DONE, 0));   // third in a row: the first stop is allowed
    send(make_sample(50, 3999, 0, 0));         // idle now: a resume reading
    send(make_sample(50, 4000, 0, 0));         // on the resume voltage: not a reading
    send(rand_item(RUN_TICKS));
    send(make_sample(50, 1, 0, 0));            // resume readings held back by the cooldown
    send(make_sample(50, 1, 3, 0));
    send(make_sample(50, 1, 0, 0));
    send(make_sample(50, 1, 0, 0));
    send(make_sample(50, 0, CHG_DONE, 0));     // unknown voltage ends the resume streak
    drain();

    configure('{7'd100, 16'd4100, 16'd4000, 16'd3300, 4'd3, 16'd10});
    run_random(90);
    drain();

    // Every reading counts at once and there is no cooldown, so the block toggles on every
    // sample but an idle one at 0 or 0xFFFF mV; a long result-side stall here fills the pipeline.
    configure('{7'd0, 16'd0, 16'hFFFF, 16'hFFFF, 4'd1, 16'd0});
    hold_reqs++;
    run_random(80);
    drain();

    // Stopping needs the top voltage and fifteen readings; resuming is impossible, so
    // the stop streak saturates.
    configure('{7'd100, 16'hFFFF, 16'd0, 16'd0, 4'd15, 16'd5});
    run_random(70);
    drain();

    // A debounce count of zero behaves as one.
    configure('{7'd80, 16'd3800, 16'd3700, 16'd3300, 4'd0, 16'd3});
    hold_reqs++;
    run_random(90);
    drain();

    repeat (3) begin
      configure('{7'($urandom_range(0, 100)), 16'($urandom_range(3000, 4500)),
                  16'($urandom_range(3000, 4500)), 16'($urandom_range(2500, 4200)),
                  4'($urandom_range(0, 15)), 16'($urandom_range(0, 40))});
      run_random(80);
      drain();
    end

    // With the longest cooldown the toggles here are refused, since an earlier toggle is
    // still recent and only a few ticks pass.
    configure('{7'd0, 16'd0, 16'hFFFF, 16'd3300, 4'd1, 16'hFFFF});
    send(make_sample(50, 1000, CHG_DONE, 50));
    send(rand_item(RUN_TICKS));
    send(make_sample(50, 1000, CHG_DONE, 50));
    send(make_sample(50, 1000, CHG_DONE, 50));
    drain();

    configure('{7'd60, 16'd4000, 16'd3950, 16'd3000, 4'd2, 16'd0});
    run_random(80);
    drain();

    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
